// File: hw/rtl/ade_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ade_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int NUM_LANES = 3;

   localparam logic [31:0] LAMBDA_RESET = 32'd65536;
   localparam logic [30:0] NORM_RESET = 31'h7fff_ffff;

   typedef enum logic [2:0] {
      CSR_LAMBDA_POS  = 3'd0,
      CSR_LAMBDA_ORI  = 3'd1,
      CSR_FORCE_GAIN  = 3'd2,
      CSR_TORQUE_GAIN = 3'd3,
      CSR_MAX_FORCE   = 3'd4,
      CSR_MAX_TORQUE  = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GD,
      ST_GDSAT,
      ST_LANE_START,
      ST_LANE_WAIT,
      ST_SUMSQ,
      ST_SQRT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic div_start;
   } lane_ctrl_type;

   typedef struct packed {
      logic upd_done;
      logic div_done;
   } lane_stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         sat32 = 32'sh7fff_ffff;
      end else if (v < -66'sd2147483648) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/adaptive_disturbance_estimator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Adaptive disturbance estimator with Euclidean norm clamp.
// req_ channel: one beat per update (func, timestamp, three rate and three
// pose errors). rsp_ channel: one beat per request with the updated estimate.
// csr_ port: plain write; index selects lambda, gain or norm limit.
// Three lanes update the x, y and z components side by side; a merging
// stage forms the sum of squares and a bit-serial square root, then the
// lanes divide by the norm in parallel.
// Without rescale the response follows the lane update and the norm check; a
// rescale adds the square root and the restoring dividers. While no torque
// beat has committed a time yet, the stored estimate is returned unchanged.
// One request is in flight at a time; req_stall is high while busy and a
// new request can be taken in the cycle after the response beat is delivered.
// Reset clears both estimates, the time record and the registers to their
// defaults. While rsp_stall is high the response beat holds.
module adaptive_disturbance_estimator_unit #(
   parameter int FRAC_BITS = ade_pkg::FRAC_BITS_DEFAULT
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire               req_func,
   input  wire [31:0]        req_timestamp,
   input  wire signed [31:0] req_rate_error_x,
   input  wire signed [31:0] req_rate_error_y,
   input  wire signed [31:0] req_rate_error_z,
   input  wire signed [31:0] req_pose_error_x,
   input  wire signed [31:0] req_pose_error_y,
   input  wire signed [31:0] req_pose_error_z,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic              rsp_group,
   output logic signed [31:0] rsp_estimate_x,
   output logic signed [31:0] rsp_estimate_y,
   output logic signed [31:0] rsp_estimate_z,
   output logic              rsp_norm_limited,
   input  wire               csr_write,
   input  wire [2:0]         csr_index,
   input  wire [31:0]        csr_data
);
   logic [31:0] lam_pos_ff, lam_ori_ff, fgain_ff, tgain_ff;
   logic [30:0] fmax_ff, tmax_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lam_pos_ff <= ade_pkg::LAMBDA_RESET;
         lam_ori_ff <= ade_pkg::LAMBDA_RESET;
         fgain_ff <= '0;
         tgain_ff <= '0;
         fmax_ff <= ade_pkg::NORM_RESET;
         tmax_ff <= ade_pkg::NORM_RESET;
      end else if (csr_write) begin
         case (csr_index)
            ade_pkg::CSR_LAMBDA_POS:  lam_pos_ff <= csr_data;
            ade_pkg::CSR_LAMBDA_ORI:  lam_ori_ff <= csr_data;
            ade_pkg::CSR_FORCE_GAIN:  fgain_ff <= csr_data;
            ade_pkg::CSR_TORQUE_GAIN: tgain_ff <= csr_data;
            ade_pkg::CSR_MAX_FORCE:   fmax_ff <= csr_data[30:0];
            ade_pkg::CSR_MAX_TORQUE:  tmax_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   ade_pkg::state_type state_ff, state_in;
   logic func_ff;
   logic [31:0] ts_ff;
   logic signed [31:0] rate_ff [3];
   logic signed [31:0] pose_ff [3];
   logic signed [31:0] fest_ff [3];
   logic signed [31:0] test_ff [3];
   logic [31:0] last_ff;
   logic tvalid_ff;
   logic [63:0] gdprod_ff;
   logic [31:0] gd_ff;
   logic rsp_valid_ff;
   logic signed [31:0] out_ff [3];
   logic lim_ff;

   logic [31:0] lambda, gain;
   logic [30:0] limit;
   logic [31:0] dt;
   logic accept;
   ade_pkg::lane_ctrl_type ctrl;
   ade_pkg::lane_stat_type stat [3];
   logic signed [31:0] est_new [3];
   logic signed [31:0] est_scaled [3];
   logic [31:0] mag [3];
   logic sat_hit [3];
   logic over, sqrt_done;
   logic [31:0] norm;
   logic sum_load, sqrt_start, commit, commit_scaled, hold;

   assign lambda = func_ff ? lam_ori_ff : lam_pos_ff;
   assign gain = func_ff ? tgain_ff : fgain_ff;
   assign limit = func_ff ? tmax_ff : fmax_ff;
   assign dt = (ts_ff >= last_ff) ? ts_ff - last_ff : '0;
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ade_pkg::ST_IDLE) || rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ctrl = '0;
      sum_load = 1'b0;
      sqrt_start = 1'b0;
      commit = 1'b0;
      commit_scaled = 1'b0;
      hold = 1'b0;
      case (state_ff)
         ade_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = ade_pkg::ST_GD;
            end
         end
         ade_pkg::ST_GD: begin
            if (tvalid_ff) begin
               state_in = ade_pkg::ST_GDSAT;
            end else begin
               hold = 1'b1;
               state_in = ade_pkg::ST_OUT;
            end
         end
         ade_pkg::ST_GDSAT: state_in = ade_pkg::ST_LANE_START;
         ade_pkg::ST_LANE_START: begin
            ctrl.start = 1'b1;
            state_in = ade_pkg::ST_LANE_WAIT;
         end
         ade_pkg::ST_LANE_WAIT: begin
            if (stat[0].upd_done) begin
               sum_load = 1'b1;
               state_in = ade_pkg::ST_SUMSQ;
            end
         end
         ade_pkg::ST_SUMSQ: state_in = ade_pkg::ST_SQRT;
         ade_pkg::ST_SQRT: begin
            if (over) begin
               sqrt_start = 1'b1;
               state_in = ade_pkg::ST_DIV_START;
            end else begin
               commit = 1'b1;
               state_in = ade_pkg::ST_OUT;
            end
         end
         ade_pkg::ST_DIV_START: begin
            if (sqrt_done) begin
               ctrl.div_start = 1'b1;
               state_in = ade_pkg::ST_DIV_WAIT;
            end
         end
         ade_pkg::ST_DIV_WAIT: begin
            if (stat[0].div_done) begin
               commit_scaled = 1'b1;
               state_in = ade_pkg::ST_OUT;
            end
         end
         ade_pkg::ST_OUT: state_in = ade_pkg::ST_IDLE;
         default: state_in = ade_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ade_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         ts_ff <= req_timestamp;
         rate_ff[0] <= req_rate_error_x;
         rate_ff[1] <= req_rate_error_y;
         rate_ff[2] <= req_rate_error_z;
         pose_ff[0] <= req_pose_error_x;
         pose_ff[1] <= req_pose_error_y;
         pose_ff[2] <= req_pose_error_z;
      end
      gdprod_ff <= gain * dt;
      gd_ff <= ((gdprod_ff >> FRAC_BITS) > 64'hffff_ffff) ? 32'hffff_ffff
                                                          : 32'(gdprod_ff >> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            fest_ff[i] <= '0;
            test_ff[i] <= '0;
         end
         last_ff <= '0;
         tvalid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lim_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (commit || commit_scaled || hold) begin
            for (int i = 0; i < 3; i++) begin
               if (commit || commit_scaled) begin
                  if (func_ff) begin
                     test_ff[i] <= commit_scaled ? est_scaled[i] : est_new[i];
                  end else begin
                     fest_ff[i] <= commit_scaled ? est_scaled[i] : est_new[i];
                  end
                  out_ff[i] <= commit_scaled ? est_scaled[i] : est_new[i];
               end else begin
                  out_ff[i] <= func_ff ? test_ff[i] : fest_ff[i];
               end
            end
            lim_ff <= commit_scaled || (!hold && (sat_hit[0] || sat_hit[1] || sat_hit[2]));
            if (func_ff) begin
               last_ff <= ts_ff;
               tvalid_ff <= 1'b1;
            end
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   for (genvar g = 0; g < ade_pkg::NUM_LANES; g++) begin : g_lane
      ade_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock(clock),
         .reset(reset),
         .ctrl(ctrl),
         .stat(stat[g]),
         .rate_err(rate_ff[g]),
         .pose_err(pose_ff[g]),
         .lambda(lambda),
         .gd(gd_ff),
         .est_old(func_ff ? test_ff[g] : fest_ff[g]),
         .limit(limit),
         .norm(norm),
         .est_new(est_new[g]),
         .sat_hit(sat_hit[g]),
         .mag(mag[g]),
         .est_scaled(est_scaled[g])
      );
   end

   ade_merge u_merge (
      .clock(clock),
      .reset(reset),
      .sum_load(sum_load),
      .sqrt_start(sqrt_start),
      .mag_x(mag[0]),
      .mag_y(mag[1]),
      .mag_z(mag[2]),
      .limit(limit),
      .over(over),
      .sqrt_done(sqrt_done),
      .norm(norm)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_group = func_ff;
   assign rsp_estimate_x = out_ff[0];
   assign rsp_estimate_y = out_ff[1];
   assign rsp_estimate_z = out_ff[2];
   assign rsp_norm_limited = lim_ff;
endmodule
`default_nettype wire

// File: hw/rtl/ade_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// one vector component: sigma, update, saturate, then rescale by limit/norm
module ade_lane #(
   parameter int FRAC_BITS = ade_pkg::FRAC_BITS_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire ade_pkg::lane_ctrl_type ctrl,
   output ade_pkg::lane_stat_type     stat,
   input  wire logic signed [31:0]    rate_err,
   input  wire logic signed [31:0]    pose_err,
   input  wire logic [31:0]           lambda,
   input  wire logic [31:0]           gd,
   input  wire logic signed [31:0]    est_old,
   input  wire logic [30:0]           limit,
   input  wire logic [31:0]           norm,
   output logic signed [31:0]         est_new,
   output logic                       sat_hit,
   output logic [31:0]                mag,
   output logic signed [31:0]         est_scaled
);
   logic [2:0] step_ff, step_in;
   logic signed [64:0] prod_ff, prod_in;
   logic signed [31:0] sigma_ff, sigma_in;
   logic signed [31:0] est_ff, est_in;
   logic sat_ff, sat_in;
   logic signed [65:0] t0;
   logic upd_done, div_done;

   always_comb begin
      step_in = step_ff;
      prod_in = prod_ff;
      sigma_in = sigma_ff;
      est_in = est_ff;
      sat_in = sat_ff;
      t0 = '0;
      upd_done = 1'b0;
      case (step_ff)
         3'd0: begin
            if (ctrl.start) begin
               prod_in = $signed({1'b0, lambda}) * pose_err;
               step_in = 3'd1;
            end
         end
         3'd1: begin
            t0 = 66'(rate_err) + 66'(prod_ff >>> FRAC_BITS);
            sigma_in = ade_pkg::sat32(t0);
            step_in = 3'd2;
         end
         3'd2: begin
            prod_in = $signed({1'b0, gd}) * sigma_ff;
            step_in = 3'd3;
         end
         3'd3: begin
            t0 = 66'(est_old) - 66'(prod_ff >>> FRAC_BITS);
            est_in = ade_pkg::sat32(t0);
            sat_in = (t0 > 66'sd2147483647) || (t0 < -66'sd2147483648);
            step_in = 3'd4;
         end
         default: begin
            upd_done = 1'b1;
            step_in = 3'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
      end else begin
         step_ff <= step_in;
      end
      prod_ff <= prod_in;
      sigma_ff <= sigma_in;
      est_ff <= est_in;
      sat_ff <= sat_in;
   end

   assign est_new = est_ff;
   assign sat_hit = sat_ff;
   assign mag = est_ff[31] ? 32'(-est_ff) : 32'(est_ff);

   // restoring divider: (mag*limit)/norm, one quotient bit per cycle
   logic [62:0] num_ff, num_in;
   logic [62:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = '0;
      div_done = 1'b0;
      if (ctrl.div_start) begin
         num_in = 63'(mag * {1'b0, limit});
         quo_in = '0;
         rem_in = '0;
         cnt_in = 7'd63;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff[31:0], num_ff[62]};
         num_in = {num_ff[61:0], 1'b0};
         if (trial >= {1'b0, norm}) begin
            rem_in = trial - {1'b0, norm};
            quo_in = {quo_ff[61:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[61:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
         end
      end else begin
         div_done = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign stat = '{upd_done: upd_done, div_done: div_done};
   assign est_scaled = est_ff[31] ? -$signed(quo_ff[31:0]) : $signed(quo_ff[31:0]);
endmodule
`default_nettype wire

// File: hw/rtl/ade_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// sum of squares over lanes, compare with limit^2, bit-serial isqrt
module ade_merge (
   input  wire          clock,
   input  wire          reset,
   input  wire          sum_load,
   input  wire          sqrt_start,
   input  wire [31:0]   mag_x,
   input  wire [31:0]   mag_y,
   input  wire [31:0]   mag_z,
   input  wire [30:0]   limit,
   output logic         over,
   output logic         sqrt_done,
   output logic [31:0]  norm
);
   logic [65:0] sq_ff [3];
   logic [65:0] sum_ff;
   logic [61:0] lim2_ff;
   logic [65:0] n_ff, n_in, res_ff, res_in, bit_ff, bit_in;
   logic busy_ff, busy_in;

   always_ff @(posedge clock) begin
      if (sum_load) begin
         sq_ff[0] <= 66'(mag_x * mag_x);
         sq_ff[1] <= 66'(mag_y * mag_y);
         sq_ff[2] <= 66'(mag_z * mag_z);
         lim2_ff <= 62'(limit * limit);
      end
      sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   assign over = (sum_ff != '0) && (sum_ff > 66'(lim2_ff));

   always_comb begin
      n_in = n_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      busy_in = busy_ff;
      if (sqrt_start) begin
         n_in = sum_ff;
         res_in = '0;
         bit_in = 66'(1) << 64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (n_ff >= res_ff + bit_ff) begin
            n_in = n_ff - (res_ff + bit_ff);
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      n_ff <= n_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign sqrt_done = !busy_ff;
   assign norm = res_ff[31:0];
endmodule
`default_nettype wire

// File: hw/rtl/ade_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ade_checker (
   input wire clock,
   input wire reset,
   input wire req_valid,
   input wire req_stall,
   input wire rsp_valid,
   input wire rsp_stall,
   input wire rsp_group
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_group))
      else $error("rsp beat dropped while stalled");
   a_no_take_while_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken with response pending");
   a_no_rsp_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response right after reset");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("response too early");
endmodule

bind adaptive_disturbance_estimator_unit ade_checker u_ade_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_group(rsp_group)
);
`default_nettype wire

// File: dv/adaptive_disturbance_estimator_unit_tb.sv
`timescale 1ns / 1ps
module adaptive_disturbance_estimator_unit_tb;

   localparam int FB = ade_pkg::FRAC_BITS_DEFAULT;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic        func;
      logic [31:0] timestamp;
      logic signed [31:0] rate_x, rate_y, rate_z;
      logic signed [31:0] pose_x, pose_y, pose_z;
   } update_beat_type;

   typedef struct packed {
      logic        group;
      logic signed [31:0] est_x, est_y, est_z;
      logic        limited;
   } estimate_beat_type;

   class estimate_scoreboard;
      logic [31:0] lam_pos, lam_ori, f_gain, t_gain;
      logic [30:0] f_max, t_max;
      longint force_est[3];
      longint torque_est[3];
      logic [31:0] last_t;
      bit t_valid;
      estimate_beat_type pending[$];
      int errors;

      function void clear();
         lam_pos = ade_pkg::LAMBDA_RESET;
         lam_ori = ade_pkg::LAMBDA_RESET;
         f_gain = 0;
         t_gain = 0;
         f_max = ade_pkg::NORM_RESET;
         t_max = ade_pkg::NORM_RESET;
         foreach (force_est[i]) begin
            force_est[i] = 0;
            torque_est[i] = 0;
         end
         last_t = 0;
         t_valid = 0;
         errors = 0;
      endfunction

      function void write_reg(ade_pkg::csr_index_type idx, logic [31:0] val);
         case (idx)
            ade_pkg::CSR_LAMBDA_POS:  lam_pos = val;
            ade_pkg::CSR_LAMBDA_ORI:  lam_ori = val;
            ade_pkg::CSR_FORCE_GAIN:  f_gain = val;
            ade_pkg::CSR_TORQUE_GAIN: t_gain = val;
            ade_pkg::CSR_MAX_FORCE:   f_max = val[30:0];
            ade_pkg::CSR_MAX_TORQUE:  t_max = val[30:0];
            default: ;
         endcase
      endfunction

      function longint clip32(longint v, inout bit hit);
         if (v > 64'sd2147483647) begin
            hit = 1;
            return 64'sd2147483647;
         end
         if (v < -64'sd2147483648) begin
            hit = 1;
            return -64'sd2147483648;
         end
         return v;
      endfunction

      function longint unsigned root(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function void note_update(update_beat_type u);
         longint est[3];
         longint rate[3], pose[3];
         longint unsigned lam, gain, lim, dt, gd, sum, nrm, m;
         longint sg, dl;
         bit hit, dummy;
         estimate_beat_type r;
         rate = '{u.rate_x, u.rate_y, u.rate_z};
         pose = '{u.pose_x, u.pose_y, u.pose_z};
         for (int i = 0; i < 3; i++) begin
            est[i] = u.func ? torque_est[i] : force_est[i];
         end
         lam = u.func ? lam_ori : lam_pos;
         gain = u.func ? t_gain : f_gain;
         lim = u.func ? t_max : f_max;
         hit = 0;
         if (t_valid) begin
            dt = (u.timestamp >= last_t) ? u.timestamp - last_t : 0;
            gd = (gain * dt) >> FB;
            if (gd > 64'hFFFF_FFFF) gd = 64'hFFFF_FFFF;
            for (int i = 0; i < 3; i++) begin
               dummy = 0;
               sg = clip32(rate[i] + ((longint'(lam) * pose[i]) >>> FB), dummy);
               dl = (longint'(gd) * sg) >>> FB;
               est[i] = clip32(est[i] - dl, hit);
            end
            sum = 0;
            for (int i = 0; i < 3; i++) begin
               m = est[i] < 0 ? -est[i] : est[i];
               sum += m * m;
            end
            if (sum != 0 && sum > lim * lim) begin
               nrm = root(sum);
               for (int i = 0; i < 3; i++) begin
                  m = est[i] < 0 ? -est[i] : est[i];
                  m = (m * lim) / nrm;
                  est[i] = est[i] < 0 ? -longint'(m) : longint'(m);
               end
               hit = 1;
            end
            for (int i = 0; i < 3; i++) begin
               if (u.func) torque_est[i] = est[i];
               else force_est[i] = est[i];
            end
         end
         if (u.func) begin
            last_t = u.timestamp;
            t_valid = 1;
         end
         r.group = u.func;
         r.est_x = est[0][31:0];
         r.est_y = est[1][31:0];
         r.est_z = est[2][31:0];
         r.limited = hit;
         pending.push_back(r);
      endfunction

      function void check_result(estimate_beat_type a);
         estimate_beat_type e;
         if (pending.size() == 0) begin
            $error("unexpected beat group=%0d", a.group);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.group !== e.group) begin
            $error("group exp %0d got %0d", e.group, a.group);
            errors++;
         end
         if (a.est_x !== e.est_x) begin
            $error("estimate_x exp %0d got %0d", e.est_x, a.est_x);
            errors++;
         end
         if (a.est_y !== e.est_y) begin
            $error("estimate_y exp %0d got %0d", e.est_y, a.est_y);
            errors++;
         end
         if (a.est_z !== e.est_z) begin
            $error("estimate_z exp %0d got %0d", e.est_z, a.est_z);
            errors++;
         end
         if (a.limited !== e.limited) begin
            $error("norm_limited exp %0d got %0d", e.limited, a.limited);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   update_beat_type req = '0;
   logic rsp_valid;
   logic rsp_stall = 1;
   logic rsp_group, rsp_norm_limited;
   logic signed [31:0] rsp_estimate_x, rsp_estimate_y, rsp_estimate_z;
   logic csr_write = 0;
   logic [2:0] csr_index = 0;
   logic [31:0] csr_data = 0;

   estimate_scoreboard sb;
   logic [31:0] now_t = 0;
   bit hold_long = 0;
   bit rsp_random = 0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   adaptive_disturbance_estimator_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_func(req.func), .req_timestamp(req.timestamp),
      .req_rate_error_x(req.rate_x), .req_rate_error_y(req.rate_y),
      .req_rate_error_z(req.rate_z), .req_pose_error_x(req.pose_x),
      .req_pose_error_y(req.pose_y), .req_pose_error_z(req.pose_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_group(rsp_group), .rsp_estimate_x(rsp_estimate_x),
      .rsp_estimate_y(rsp_estimate_y), .rsp_estimate_z(rsp_estimate_z),
      .rsp_norm_limited(rsp_norm_limited),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(1, 3);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_group, rsp_estimate_x, rsp_estimate_y,
                           rsp_estimate_z, rsp_norm_limited});
   end

   // receiver stall process
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_long) begin
            @(posedge clock);
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            rsp_stall <= 0;
            hold_long = 0;
         end else if (!rsp_random) begin
            @(posedge clock);
            rsp_stall <= 0;
         end else begin
            @(posedge clock);
            n = gap_len();
            if (n > 0) begin
               rsp_stall <= 1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL adaptive_disturbance_estimator_unit");
         $finish;
      end
   end

   task automatic write_reg(ade_pkg::csr_index_type idx, logic [31:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic send(update_beat_type u, bit gaps);
      int n;
      if (gaps) begin
         n = gap_len();
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req <= u;
      do @(posedge clock); while (req_stall);
      sb.note_update(u);
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   function automatic logic [31:0] rnd_val();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 1) ? 32'(-$urandom_range(0, 200000)) :
               32'($urandom_range(0, 200000));
         3: return $urandom_range(0, 3) - 2;
         default: return $urandom;
      endcase
   endfunction

   function automatic update_beat_type rnd_update(bit func);
      update_beat_type u;
      u.func = func;
      case ($urandom_range(0, 9))
         0: u.timestamp = $urandom;
         1: u.timestamp = now_t - $urandom_range(0, 500);
         default: u.timestamp = now_t + $urandom_range(0, 3000);
      endcase
      if (func) now_t = u.timestamp;
      u.rate_x = rnd_val();
      u.rate_y = rnd_val();
      u.rate_z = rnd_val();
      u.pose_x = rnd_val();
      u.pose_y = rnd_val();
      u.pose_z = rnd_val();
      return u;
   endfunction

   task automatic rnd_regs(bit extreme);
      for (int i = 0; i < 6; i++) begin
         logic [31:0] v;
         if (extreme) v = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
         else case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 1 << 18);
            1: v = $urandom_range(1 << 14, 1 << 20);
            2: v = $urandom;
            default: v = $urandom_range(0, 1 << 16);
         endcase
         write_reg(ade_pkg::csr_index_type'(i), v);
      end
   endtask

   initial begin
      update_beat_type u;
      sb = new();
      sb.clear();
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: no time yet, then extremes and backward time
      u = '{0, 32'd100, 32'sd1, -32'sd1, 32'sd0, 32'sd5, 32'sd6, 32'sd7};
      send(u, 0);
      u.func = 1;
      send(u, 0);
      drain();
      write_reg(ade_pkg::CSR_FORCE_GAIN, 32'h0001_0000);
      write_reg(ade_pkg::CSR_TORQUE_GAIN, 32'h0000_8000);
      write_reg(ade_pkg::CSR_MAX_FORCE, 32'h0010_0000);
      write_reg(ade_pkg::CSR_MAX_TORQUE, 32'hffff_ffff);
      write_reg(ade_pkg::CSR_LAMBDA_POS, 32'hffff_ffff);
      write_reg(ade_pkg::CSR_LAMBDA_ORI, 32'h0);
      u = '{0, 32'd200, 32'h7fff_ffff, 32'h8000_0000, 32'h0,
            32'h7fff_ffff, 32'h8000_0000, 32'h1};
      send(u, 0);
      u.func = 1;
      send(u, 0);
      u = '{1, 32'd50, 32'sd3, 32'sd4, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
      send(u, 0);
      u = '{0, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      send(u, 0);
      u = '{1, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
      send(u, 0);
      drain();
      write_reg(ade_pkg::CSR_MAX_FORCE, 32'h0);
      write_reg(ade_pkg::CSR_MAX_TORQUE, 32'h0);
      u = '{0, 32'hffff_ffff, 32'sd9, 32'sd9, 32'sd9, 32'sd0, 32'sd0, 32'sd0};
      send(u, 0);
      u.func = 1;
      send(u, 0);
      drain();
      now_t = 32'h1000;

      // pressure: receiver holds off while sender keeps going
      hold_long = 1;
      for (int i = 0; i < 10; i++) send(rnd_update($urandom_range(0, 1)), 0);
      drain();

      rsp_random = 1;
      for (int ph = 0; ph < 8; ph++) begin
         rnd_regs(ph == 3);
         for (int i = 0; i < 240; i++)
            send(rnd_update($urandom_range(0, 1)), ph != 5);
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("PASS adaptive_disturbance_estimator_unit");
      end else begin
         $display("FAIL adaptive_disturbance_estimator_unit");
      end
      $finish;
   end
endmodule

// File: sim.f
hw/rtl/ade_pkg.sv
hw/rtl/ade_lane.sv
hw/rtl/ade_merge.sv
hw/rtl/adaptive_disturbance_estimator_unit.sv
hw/rtl/ade_checker.sv
dv/adaptive_disturbance_estimator_unit_tb.sv
